>>> rtl/core/rcs_pkg.sv
// shared types and constants for the rotation coordinate stepper
// no dependencies; used by every module of the block
package rcs_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int COEF_BITS      = 10;
	localparam int CFG_IDX_BITS   = 3;

	typedef logic signed [COEF_BITS-1:0] coef_t;

	// reset value of the two diagonal gains: unity at 8 fraction bits
	localparam coef_t COEF_UNITY = coef_t'(256);
	localparam coef_t COEF_ZERO  = coef_t'(0);

	typedef struct packed {
		coef_t line_from_line;
		coef_t line_from_col;
		coef_t col_from_line;
		coef_t col_from_col;
	} coef_set_t;

	typedef enum logic [1:0] {
		OP_ROTATE    = 2'd0,
		OP_STEP      = 2'd1,
		OP_BOX_RESET = 2'd2,
		OP_BOX_WIDEN = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_LINE_FROM_LINE = 3'd0,
		REG_LINE_FROM_COL  = 3'd1,
		REG_COL_FROM_LINE  = 3'd2,
		REG_COL_FROM_COL   = 3'd3,
		REG_ORIGIN_LINE    = 3'd4,
		REG_ORIGIN_COL     = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} stage_ctl_t;

endpackage

>>> rtl/core/rotation_coordinate_stepper_top.sv
// top level of the rotation coordinate stepper
// depends on rcs_pkg, rcs_cfg, rcs_rotate, rcs_state
//
// Fixed-point rotation address generator. It takes one operation per clock
// while item_stall is low (rotate, step one column, rotate and reset box,
// rotate and widen box) and returns one result per operation: the position
// and bounding box after it. From input transfer to result the data passes
// an input register holding the offsets from the origin, a register after
// the four gain multipliers, and the position/box register, which is also
// the result register. Steps and box updates read that register directly,
// so items stream back to back at one per cycle with no gaps while
// result_stall is low. The result register frees itself in the cycle its
// transfer completes, and the two earlier stages keep taking input while a
// finished result waits to be taken, until they are full. Configuration is
// always ready and must be written only while the block is empty.
module rotation_coordinate_stepper_top #(
	parameter int COORD_BITS = rcs_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS = rcs_pkg::FRAC_BITS_DEF,
	localparam int POS_W = COORD_BITS + 3,
	localparam int CFG_W = (COORD_BITS > rcs_pkg::COEF_BITS) ?
		COORD_BITS : rcs_pkg::COEF_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rcs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [CFG_W-1:0]                    cfg_data,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [1:0]                          opcode,
	input  logic signed [COORD_BITS-1:0]        src_line,
	input  logic signed [COORD_BITS-1:0]        src_col,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [POS_W-1:0]             rot_line,
	output logic signed [POS_W-1:0]             rot_col,
	output logic [FRAC_BITS-1:0]                line_fraction,
	output logic [FRAC_BITS-1:0]                col_fraction,
	output logic signed [POS_W-1:0]             box_line_min,
	output logic signed [POS_W-1:0]             box_line_max,
	output logic signed [POS_W-1:0]             box_col_min,
	output logic signed [POS_W-1:0]             box_col_max
);

	localparam int SUM_W = COORD_BITS + rcs_pkg::COEF_BITS + 2;

	rcs_pkg::coef_set_t coef;
	logic signed [COORD_BITS-1:0] origin_line, origin_col;
	rcs_pkg::stage_ctl_t ctl_s2;
	logic signed [SUM_W-1:0] lsum_s2, ksum_s2;
	logic down_ready;

	assign cfg_ready = 1'b1;

	rcs_cfg #(
		.COORD_BITS (COORD_BITS),
		.CFG_W      (CFG_W)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.coef        (coef),
		.origin_line (origin_line),
		.origin_col  (origin_col)
	);

	rcs_rotate #(
		.COORD_BITS (COORD_BITS),
		.SUM_W      (SUM_W)
	) u_rotate (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.opcode      (opcode),
		.src_line    (src_line),
		.src_col     (src_col),
		.coef        (coef),
		.origin_line (origin_line),
		.origin_col  (origin_col),
		.down_ready  (down_ready),
		.ctl_s2      (ctl_s2),
		.lsum_s2     (lsum_s2),
		.ksum_s2     (ksum_s2)
	);

	rcs_state #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS),
		.SUM_W      (SUM_W),
		.POS_W      (POS_W)
	) u_state (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl_s2        (ctl_s2),
		.lsum_s2       (lsum_s2),
		.ksum_s2       (ksum_s2),
		.coef          (coef),
		.origin_line   (origin_line),
		.origin_col    (origin_col),
		.down_ready    (down_ready),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.rot_line      (rot_line),
		.rot_col       (rot_col),
		.line_fraction (line_fraction),
		.col_fraction  (col_fraction),
		.box_line_min  (box_line_min),
		.box_line_max  (box_line_max),
		.box_col_min   (box_col_min),
		.box_col_max   (box_col_max)
	);

endmodule

>>> rtl/core/rcs_cfg.sv
// configuration registers: rotation gains and origin
// depends on rcs_pkg
module rcs_cfg #(
	parameter int COORD_BITS = rcs_pkg::COORD_BITS_DEF,
	parameter int CFG_W = COORD_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [rcs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [CFG_W-1:0]                   cfg_data,
	output rcs_pkg::coef_set_t                 coef,
	output logic signed [COORD_BITS-1:0]       origin_line,
	output logic signed [COORD_BITS-1:0]       origin_col
);

	rcs_pkg::coef_set_t coef_q;
	logic signed [COORD_BITS-1:0] origin_line_q;
	logic signed [COORD_BITS-1:0] origin_col_q;
	rcs_pkg::coef_t wr_coef;
	logic signed [COORD_BITS-1:0] wr_origin;

	assign wr_coef   = rcs_pkg::coef_t'(cfg_data[rcs_pkg::COEF_BITS-1:0]);
	assign wr_origin = $signed(cfg_data[COORD_BITS-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.line_from_line <= rcs_pkg::COEF_UNITY;
			coef_q.line_from_col  <= rcs_pkg::COEF_ZERO;
			coef_q.col_from_line  <= rcs_pkg::COEF_ZERO;
			coef_q.col_from_col   <= rcs_pkg::COEF_UNITY;
			origin_line_q         <= '0;
			origin_col_q          <= '0;
		end else if (cfg_valid) begin
			case (rcs_pkg::cfg_reg_t'(cfg_index))
				rcs_pkg::REG_LINE_FROM_LINE: coef_q.line_from_line <= wr_coef;
				rcs_pkg::REG_LINE_FROM_COL:  coef_q.line_from_col  <= wr_coef;
				rcs_pkg::REG_COL_FROM_LINE:  coef_q.col_from_line  <= wr_coef;
				rcs_pkg::REG_COL_FROM_COL:   coef_q.col_from_col   <= wr_coef;
				rcs_pkg::REG_ORIGIN_LINE:    origin_line_q         <= wr_origin;
				rcs_pkg::REG_ORIGIN_COL:     origin_col_q          <= wr_origin;
				default: ;
			endcase
		end
	end

	assign coef        = coef_q;
	assign origin_line = origin_line_q;
	assign origin_col  = origin_col_q;

endmodule

>>> rtl/core/rcs_rotate.sv
// input register and rotation products: offsets from origin, then the two
// fixed-point weighted sums; depends on rcs_pkg
module rcs_rotate #(
	parameter int COORD_BITS = rcs_pkg::COORD_BITS_DEF,
	parameter int SUM_W = COORD_BITS + rcs_pkg::COEF_BITS + 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [1:0]                    opcode,
	input  logic signed [COORD_BITS-1:0]  src_line,
	input  logic signed [COORD_BITS-1:0]  src_col,
	input  rcs_pkg::coef_set_t            coef,
	input  logic signed [COORD_BITS-1:0]  origin_line,
	input  logic signed [COORD_BITS-1:0]  origin_col,
	input  logic                          down_ready,
	output rcs_pkg::stage_ctl_t           ctl_s2,
	output logic signed [SUM_W-1:0]       lsum_s2,
	output logic signed [SUM_W-1:0]       ksum_s2
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = DW + rcs_pkg::COEF_BITS;

	rcs_pkg::stage_ctl_t ctl_s1;
	rcs_pkg::stage_ctl_t ctl_s2_q;
	logic signed [DW-1:0] dl_s1, dk_s1;
	logic signed [PW-1:0] p_ll, p_lc, p_cl, p_cc;
	logic ready_s1, ready_s2;

	assign ready_s2   = !ctl_s2_q.valid || down_ready;
	assign ready_s1   = !ctl_s1.valid || ready_s2;
	assign item_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1.valid   <= 1'b0;
			ctl_s1.op      <= rcs_pkg::OP_ROTATE;
			ctl_s2_q.valid <= 1'b0;
			ctl_s2_q.op    <= rcs_pkg::OP_ROTATE;
		end else begin
			if (ready_s1) begin
				ctl_s1.valid <= item_valid;
				ctl_s1.op    <= rcs_pkg::op_t'(opcode);
			end
			if (ready_s2) begin
				ctl_s2_q <= ctl_s1;
			end
		end
	end

	// offsets are exact at one bit wider than the coordinates
	always_ff @(posedge clk) begin
		if (ready_s1 && item_valid) begin
			dl_s1 <= DW'(src_line) - DW'(origin_line);
			dk_s1 <= DW'(src_col) - DW'(origin_col);
		end
	end

	assign p_ll = PW'(dl_s1) * PW'(coef.line_from_line);
	assign p_lc = PW'(dk_s1) * PW'(coef.line_from_col);
	assign p_cl = PW'(dl_s1) * PW'(coef.col_from_line);
	assign p_cc = PW'(dk_s1) * PW'(coef.col_from_col);

	always_ff @(posedge clk) begin
		if (ready_s2 && ctl_s1.valid) begin
			lsum_s2 <= SUM_W'(p_ll) + SUM_W'(p_lc);
			ksum_s2 <= SUM_W'(p_cl) + SUM_W'(p_cc);
		end
	end

	assign ctl_s2 = ctl_s2_q;

endmodule

>>> rtl/core/rcs_state.sv
// position, fraction and bounding box registers; these double as the result
// register. floor split, column step and box update; depends on rcs_pkg
module rcs_state #(
	parameter int COORD_BITS = rcs_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS = rcs_pkg::FRAC_BITS_DEF,
	parameter int SUM_W = COORD_BITS + rcs_pkg::COEF_BITS + 2,
	parameter int POS_W = COORD_BITS + 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rcs_pkg::stage_ctl_t           ctl_s2,
	input  logic signed [SUM_W-1:0]       lsum_s2,
	input  logic signed [SUM_W-1:0]       ksum_s2,
	input  rcs_pkg::coef_set_t            coef,
	input  logic signed [COORD_BITS-1:0]  origin_line,
	input  logic signed [COORD_BITS-1:0]  origin_col,
	output logic                          down_ready,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic signed [POS_W-1:0]       rot_line,
	output logic signed [POS_W-1:0]       rot_col,
	output logic [FRAC_BITS-1:0]          line_fraction,
	output logic [FRAC_BITS-1:0]          col_fraction,
	output logic signed [POS_W-1:0]       box_line_min,
	output logic signed [POS_W-1:0]       box_line_max,
	output logic signed [POS_W-1:0]       box_col_min,
	output logic signed [POS_W-1:0]       box_col_max
);

	localparam int IW = SUM_W - FRAC_BITS;
	localparam int SW = ((FRAC_BITS + 1 > rcs_pkg::COEF_BITS) ?
		FRAC_BITS + 1 : rcs_pkg::COEF_BITS) + 1;
	localparam int SIW = SW - FRAC_BITS;

	logic result_valid_q;
	logic signed [POS_W-1:0] pos_line_q, pos_col_q;
	logic [FRAC_BITS-1:0] frac_line_q, frac_col_q;
	logic signed [POS_W-1:0] min_line_q, max_line_q, min_col_q, max_col_q;

	logic signed [IW-1:0] rl_int, rk_int;
	logic signed [IW+POS_W-1:0] rl_ext, rk_ext;
	logic signed [POS_W-1:0] rot_line_new, rot_col_new;
	logic signed [SW-1:0] sl_sum, sk_sum;
	logic signed [SIW-1:0] sl_int, sk_int;
	logic signed [POS_W-1:0] step_line_new, step_col_new;
	logic signed [POS_W-1:0] nl, nk;
	logic [FRAC_BITS-1:0] nfl, nfk;
	logic take;

	assign down_ready = !result_valid_q || !result_stall;
	assign take       = ctl_s2.valid && down_ready;

	// rotate: floor is the arithmetic shift, the fraction the low bits
	assign rl_int       = $signed(lsum_s2[SUM_W-1:FRAC_BITS]);
	assign rk_int       = $signed(ksum_s2[SUM_W-1:FRAC_BITS]);
	assign rl_ext       = (IW+POS_W)'(rl_int);
	assign rk_ext       = (IW+POS_W)'(rk_int);
	assign rot_line_new = rl_ext[POS_W-1:0] + POS_W'(origin_line);
	assign rot_col_new  = rk_ext[POS_W-1:0] + POS_W'(origin_col);

	// step: fraction plus column gain, carry folds into the integer part
	assign sl_sum        = SW'($signed({1'b0, frac_line_q})) + SW'(coef.line_from_col);
	assign sk_sum        = SW'($signed({1'b0, frac_col_q})) + SW'(coef.col_from_col);
	assign sl_int        = $signed(sl_sum[SW-1:FRAC_BITS]);
	assign sk_int        = $signed(sk_sum[SW-1:FRAC_BITS]);
	assign step_line_new = pos_line_q + POS_W'(sl_int);
	assign step_col_new  = pos_col_q + POS_W'(sk_int);

	always_comb begin
		if (ctl_s2.op == rcs_pkg::OP_STEP) begin
			nl  = step_line_new;
			nk  = step_col_new;
			nfl = sl_sum[FRAC_BITS-1:0];
			nfk = sk_sum[FRAC_BITS-1:0];
		end else begin
			nl  = rot_line_new;
			nk  = rot_col_new;
			nfl = lsum_s2[FRAC_BITS-1:0];
			nfk = ksum_s2[FRAC_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			pos_line_q     <= '0;
			pos_col_q      <= '0;
			frac_line_q    <= '0;
			frac_col_q     <= '0;
			min_line_q     <= '0;
			max_line_q     <= '0;
			min_col_q      <= '0;
			max_col_q      <= '0;
		end else if (take) begin
			result_valid_q <= 1'b1;
			pos_line_q     <= nl;
			pos_col_q      <= nk;
			frac_line_q    <= nfl;
			frac_col_q     <= nfk;
			case (ctl_s2.op)
				rcs_pkg::OP_BOX_RESET: begin
					min_line_q <= nl;
					max_line_q <= nl;
					min_col_q  <= nk;
					max_col_q  <= nk;
				end
				rcs_pkg::OP_BOX_WIDEN: begin
					if (nl < min_line_q) min_line_q <= nl;
					if (nl > max_line_q) max_line_q <= nl;
					if (nk < min_col_q) min_col_q <= nk;
					if (nk > max_col_q) max_col_q <= nk;
				end
				default: ;
			endcase
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid  = result_valid_q;
	assign rot_line      = pos_line_q;
	assign rot_col       = pos_col_q;
	assign line_fraction = frac_line_q;
	assign col_fraction  = frac_col_q;
	assign box_line_min  = min_line_q;
	assign box_line_max  = max_line_q;
	assign box_col_min   = min_col_q;
	assign box_col_max   = max_col_q;

endmodule

>>> verif/testbench.sv
// self-checking testbench for rotation_coordinate_stepper_top
// depends on rcs_pkg and the block's rtl; carries its own rotation and box predictor
module testbench;
	import rcs_pkg::*;

	localparam int COORD = COORD_BITS_DEF;
	localparam int FRAC = FRAC_BITS_DEF;
	localparam int POS_W = COORD + 3;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASES = 12;
	localparam int ITEMS_PER_PHASE = 100;

	typedef struct packed {
		logic signed [POS_W-1:0] rot_line;
		logic signed [POS_W-1:0] rot_col;
		logic [FRAC-1:0] line_fraction;
		logic [FRAC-1:0] col_fraction;
		logic signed [POS_W-1:0] line_lo;
		logic signed [POS_W-1:0] line_hi;
		logic signed [POS_W-1:0] col_lo;
		logic signed [POS_W-1:0] col_hi;
	} position_t;

	class rotation_predictor;
		coef_t g_ll, g_lk, g_kl, g_kk;
		logic signed [COORD-1:0] org_line, org_col;
		logic signed [POS_W-1:0] line_pos, col_pos, line_lo, line_hi, col_lo, col_hi;
		logic [FRAC-1:0] line_frac, col_frac;
		position_t expected_positions[$];
		int errors;

		function new();
			g_ll = COEF_UNITY;
			g_lk = COEF_ZERO;
			g_kl = COEF_ZERO;
			g_kk = COEF_UNITY;
			org_line = '0;
			org_col = '0;
			line_pos = '0;
			col_pos = '0;
			line_lo = '0;
			line_hi = '0;
			col_lo = '0;
			col_hi = '0;
			line_frac = '0;
			col_frac = '0;
			errors = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [COORD-1:0] data);
			case (idx)
				REG_LINE_FROM_LINE: g_ll = coef_t'(data[COEF_BITS-1:0]);
				REG_LINE_FROM_COL:  g_lk = coef_t'(data[COEF_BITS-1:0]);
				REG_COL_FROM_LINE:  g_kl = coef_t'(data[COEF_BITS-1:0]);
				REG_COL_FROM_COL:   g_kk = coef_t'(data[COEF_BITS-1:0]);
				REG_ORIGIN_LINE:    org_line = data;
				REG_ORIGIN_COL:     org_col = data;
				default: ;
			endcase
		endfunction

		// floor split of a fixed-point value, integer part wraps at POS_W bits
		function void split(longint full, longint base, output logic signed [POS_W-1:0] pos,
				output logic [FRAC-1:0] frac);
			frac = full[FRAC-1:0];
			pos = POS_W'((full >>> FRAC) + base);
		endfunction

		function int pending();
			return expected_positions.size();
		endfunction

		function void note_item(op_t op, logic signed [COORD-1:0] l, logic signed [COORD-1:0] c);
			longint dl, dk;
			position_t res;
			if (op == OP_STEP) begin
				split(longint'(line_frac) + longint'(g_lk), longint'(line_pos), line_pos, line_frac);
				split(longint'(col_frac) + longint'(g_kk), longint'(col_pos), col_pos, col_frac);
			end else begin
				dl = longint'(l) - longint'(org_line);
				dk = longint'(c) - longint'(org_col);
				split(dl * longint'(g_ll) + dk * longint'(g_lk), longint'(org_line),
					line_pos, line_frac);
				split(dl * longint'(g_kl) + dk * longint'(g_kk), longint'(org_col),
					col_pos, col_frac);
				if (op == OP_BOX_RESET) begin
					line_lo = line_pos;
					line_hi = line_pos;
					col_lo = col_pos;
					col_hi = col_pos;
				end else if (op == OP_BOX_WIDEN) begin
					if (line_pos < line_lo) line_lo = line_pos;
					if (line_pos > line_hi) line_hi = line_pos;
					if (col_pos < col_lo) col_lo = col_pos;
					if (col_pos > col_hi) col_hi = col_pos;
				end
			end
			res = '{line_pos, col_pos, line_frac, col_frac, line_lo, line_hi, col_lo, col_hi};
			expected_positions.push_back(res);
		endfunction

		function void compare(string field, logic signed [POS_W-1:0] want,
				logic signed [POS_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(position_t got);
			position_t want;
			if (expected_positions.size() == 0) begin
				$error("result transfer with no expected position waiting");
				errors++;
				return;
			end
			want = expected_positions.pop_front();
			compare("rot_line", want.rot_line, got.rot_line);
			compare("rot_col", want.rot_col, got.rot_col);
			compare("line_fraction", want.line_fraction, got.line_fraction);
			compare("col_fraction", want.col_fraction, got.col_fraction);
			compare("box_line_min", want.line_lo, got.line_lo);
			compare("box_line_max", want.line_hi, got.line_hi);
			compare("box_col_min", want.col_lo, got.col_lo);
			compare("box_col_max", want.col_hi, got.col_hi);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [COORD-1:0] cfg_data;
	logic item_valid;
	logic item_stall;
	logic [1:0] opcode;
	logic signed [COORD-1:0] src_line;
	logic signed [COORD-1:0] src_col;
	logic result_valid;
	logic result_stall;
	logic signed [POS_W-1:0] rot_line, rot_col;
	logic [FRAC-1:0] line_fraction, col_fraction;
	logic signed [POS_W-1:0] box_line_min, box_line_max, box_col_min, box_col_max;

	rotation_predictor pred;
	int items_sent;
	bit idling_on;
	int hold_reqs;
	int hold_served;
	int hold_left;

	rotation_coordinate_stepper_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.opcode(opcode),
		.src_line(src_line),
		.src_col(src_col),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.rot_line(rot_line),
		.rot_col(rot_col),
		.line_fraction(line_fraction),
		.col_fraction(col_fraction),
		.box_line_min(box_line_min),
		.box_line_max(box_line_max),
		.box_col_min(box_col_min),
		.box_col_max(box_col_max)
	);

	always #5 clk = ~clk;

	// both channels are observed at the rising edge, inputs were set at the falling one
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				pred.note_item(op_t'(opcode), src_line, src_col);
			if (result_valid && !result_stall)
				pred.check_result('{rot_line, rot_col, line_fraction, col_fraction,
					box_line_min, box_line_max, box_col_min, box_col_max});
		end
	end

	// receiver: random stalls plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_served != hold_reqs) begin
			hold_served = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= idling_on && ($urandom_range(0, 99) < 7);
		end
	end

	task automatic send_item(op_t op, logic [COORD-1:0] l, logic [COORD-1:0] c);
		if (idling_on && $urandom_range(0, 99) < 7) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat ($urandom_range(0, 4)) @(negedge clk);
		end
		@(negedge clk);
		item_valid <= 1'b1;
		opcode <= op;
		src_line <= l;
		src_col <= c;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [COORD-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		pred.write_reg(idx, data);
	endtask

	// stop offering items, then wait for every expected result
	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pred.pending() != 0) @(negedge clk);
	endtask

	// registers change only with the block empty
	task automatic set_config(logic [COORD-1:0] ll, logic [COORD-1:0] lk, logic [COORD-1:0] kl,
			logic [COORD-1:0] kk, logic [COORD-1:0] ol, logic [COORD-1:0] oc);
		wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		repeat (4) @(negedge clk);
		write_reg(REG_LINE_FROM_LINE, ll);
		write_reg(REG_LINE_FROM_COL, lk);
		write_reg(REG_COL_FROM_LINE, kl);
		write_reg(REG_COL_FROM_COL, kk);
		write_reg(REG_ORIGIN_LINE, ol);
		write_reg(REG_ORIGIN_COL, oc);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [COORD-1:0] pick_gain();
		case ($urandom_range(0, 9))
			0: return 16'sd256;
			1: return -16'sd256;
			2: return '0;
			3: return COORD'($urandom);
			default: return COORD'(int'($urandom_range(0, 512)) - 256);
		endcase
	endfunction

	function automatic logic [COORD-1:0] pick_origin();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2, 3: return COORD'($urandom);
			default: return COORD'(int'($urandom_range(0, 6000)) - 3000);
		endcase
	endfunction

	function automatic logic [COORD-1:0] near(int centre, int span);
		return COORD'(centre + int'($urandom_range(0, 2 * span)) - span);
	endfunction

	// one rotated frame: box reset, then rows walked by column steps, row ends widen box
	task automatic send_frame();
		int rows, len, l0, c0;
		rows = $urandom_range(1, 4);
		if ($urandom_range(0, 9) == 0) begin
			l0 = int'($signed(COORD'($urandom)));
			c0 = int'($signed(COORD'($urandom)));
		end else begin
			l0 = int'($signed(pred.org_line)) + int'($urandom_range(0, 400)) - 200;
			c0 = int'($signed(pred.org_col)) + int'($urandom_range(0, 400)) - 200;
		end
		send_item(OP_BOX_RESET, near(l0, 40), near(c0, 40));
		for (int r = 0; r < rows; r++) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
			send_item(($urandom_range(0, 1) != 0) ? OP_BOX_WIDEN : OP_ROTATE,
				COORD'(l0 + r), COORD'(c0));
			repeat (len) send_item(OP_STEP, COORD'($urandom), COORD'($urandom));
			send_item(OP_BOX_WIDEN, COORD'(l0 + r), COORD'(c0 + len));
		end
	endtask

	initial begin
		int phase_end, guard;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		opcode = '0;
		src_line = '0;
		src_col = '0;
		result_stall = 1'b0;
		items_sent = 0;
		idling_on = 1'b1;
		hold_reqs = 0;
		hold_served = 0;
		hold_left = 0;
		pred = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset gains: the box widens from its zeros before any box reset
		send_item(OP_BOX_WIDEN, 16'sd100, -16'sd50);
		send_item(OP_ROTATE, 16'h7fff, 16'h8000);
		send_item(OP_STEP, 16'h0000, 16'h0000);
		send_item(OP_BOX_WIDEN, 16'h8000, 16'h7fff);
		send_item(OP_BOX_RESET, 16'hffff, 16'h0001);
		send_item(OP_STEP, 16'hffff, 16'hffff);
		send_item(OP_BOX_WIDEN, 16'h0000, 16'h0000);

		// gains past the nominal range and extreme origins force position wrap
		set_config(16'hfe00, 16'h01ff, -16'sd256, 16'sd256, 16'h8000, 16'h7fff);
		send_item(OP_ROTATE, 16'h7fff, 16'h8000);
		send_item(OP_BOX_RESET, 16'h8000, 16'h7fff);
		repeat (3) send_item(OP_STEP, 16'h5555, 16'haaaa);
		send_item(OP_BOX_WIDEN, 16'h7fff, 16'h8000);
		send_item(OP_ROTATE, 16'sd12345, -16'sd321);

		set_config(16'sd256, -16'sd256, 16'sd256, -16'sd256, 16'h7fff, 16'h8000);
		send_item(OP_BOX_RESET, 16'h0000, 16'h0000);
		send_item(OP_STEP, 16'haaaa, 16'h5555);
		send_item(OP_BOX_WIDEN, 16'h8000, 16'h8000);
		send_item(OP_BOX_WIDEN, 16'h7fff, 16'h7fff);
		send_item(OP_ROTATE, 16'h8000, 16'h7fff);
		send_item(OP_STEP, 16'h0000, 16'hffff);

		for (int ph = 0; ph < PHASES; ph++) begin
			set_config(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
				pick_origin(), pick_origin());
			idling_on = (ph != 5);
			if (ph == 2)
				hold_reqs++;
			if (ph == 8) begin
				send_frame();
				wait_drained();
			end
			phase_end = items_sent + ITEMS_PER_PHASE;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 99) < 80)
					send_frame();
				else
					send_item(op_t'($urandom_range(0, 3)), COORD'($urandom), COORD'($urandom));
			end
		end
		idling_on = 1'b1;
		@(negedge clk);
		item_valid <= 1'b0;

		guard = 0;
		while (pred.pending() != 0 && guard < 5000) begin
			@(negedge clk);
			guard++;
		end
		repeat (10) @(negedge clk);
		if (pred.pending() != 0) begin
			$error("%0d expected positions never arrived", pred.pending());
			pred.errors++;
		end
		if (pred.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
